// ----- hdl/ce8_pkg.sv -----
// Shared types and constants for the 8-bit CPU execute unit.
package ce8_pkg;

	localparam logic [7:0] FlagsReset = 8'h20;
	localparam int unsigned FlagC = 0;
	localparam int unsigned FlagZ = 1;
	localparam int unsigned FlagV = 6;
	localparam int unsigned FlagN = 7;

	typedef enum logic [5:0] {
		OP_LDA = 6'd0, OP_LDX = 6'd1, OP_LDY = 6'd2, OP_STA = 6'd3,
		OP_STX = 6'd4, OP_STY = 6'd5, OP_ADC = 6'd6, OP_SBC = 6'd7,
		OP_AND = 6'd8, OP_ORA = 6'd9, OP_EOR = 6'd10, OP_CMP = 6'd11,
		OP_CPX = 6'd12, OP_CPY = 6'd13, OP_BIT = 6'd14, OP_INC = 6'd15,
		OP_DEC = 6'd16, OP_ASLM = 6'd17, OP_LSRM = 6'd18, OP_ROLM = 6'd19,
		OP_RORM = 6'd20, OP_ASLA = 6'd21, OP_LSRA = 6'd22, OP_ROLA = 6'd23,
		OP_RORA = 6'd24, OP_INY = 6'd25, OP_DEX = 6'd26, OP_DEY = 6'd27,
		OP_TAX = 6'd28, OP_TAY = 6'd29, OP_TXA = 6'd30, OP_TYA = 6'd31,
		OP_SEC = 6'd32, OP_CLC = 6'd33, OP_JMP = 6'd34, OP_BPL = 6'd35,
		OP_BMI = 6'd36, OP_BCC = 6'd37, OP_BCS = 6'd38, OP_BNE = 6'd39,
		OP_BEQ = 6'd40, OP_BVC = 6'd41, OP_BVS = 6'd42
	} opcode_t;

	typedef enum logic [3:0] {
		K_NOP, K_LOAD, K_STORE, K_ADD, K_LOGIC, K_CMP, K_BIT, K_INCDEC,
		K_SHIFT, K_TRANSFER, K_FLAGC, K_JUMP, K_BRANCH
	} kind_t;

	typedef enum logic [2:0] {R_NONE, R_A, R_X, R_Y, R_MEM} rsel_t;

	typedef enum logic [1:0] {L_AND, L_OR, L_EOR} lop_t;

	// Order matches the branch opcode pairs: N, C, Z, V.
	typedef enum logic [1:0] {BF_N, BF_C, BF_Z, BF_V} bflag_t;

	typedef struct packed {
		kind_t  kind;
		rsel_t  src;
		rsel_t  dst;
		logic   alt;     // SBC invert, DEC, shift right
		logic   rotate;
		lop_t   lop;
		bflag_t bflag;
		logic   bval;    // branch polarity, or the value SEC/CLC put in C
	} uop_t;

	typedef struct packed {
		uop_t        uop;
		logic [15:0] address;
		logic [7:0]  mem_data;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ----- hdl/ce8_front.sv -----
// Front end: accepts words and classifies the opcode into a micro-op.
module ce8_front import ce8_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  mem_data,
	input  qstat_t      q_stat,
	output logic        push,
	output entry_t      push_data
);

	function automatic uop_t decode(logic [5:0] op);
		uop_t       u;
		logic [5:0] boff;
		u = '{kind: K_NOP, src: R_NONE, dst: R_NONE, alt: 1'b0, rotate: 1'b0,
			lop: L_AND, bflag: BF_N, bval: 1'b0};
		boff = op - OP_BPL;
		case (op) inside
			OP_LDA: begin u.kind = K_LOAD; u.dst = R_A; end
			OP_LDX: begin u.kind = K_LOAD; u.dst = R_X; end
			OP_LDY: begin u.kind = K_LOAD; u.dst = R_Y; end
			OP_STA: begin u.kind = K_STORE; u.src = R_A; end
			OP_STX: begin u.kind = K_STORE; u.src = R_X; end
			OP_STY: begin u.kind = K_STORE; u.src = R_Y; end
			OP_ADC: begin u.kind = K_ADD; u.dst = R_A; end
			OP_SBC: begin u.kind = K_ADD; u.dst = R_A; u.alt = 1'b1; end
			OP_AND: begin u.kind = K_LOGIC; u.dst = R_A; u.lop = L_AND; end
			OP_ORA: begin u.kind = K_LOGIC; u.dst = R_A; u.lop = L_OR; end
			OP_EOR: begin u.kind = K_LOGIC; u.dst = R_A; u.lop = L_EOR; end
			OP_CMP: begin u.kind = K_CMP; u.src = R_A; end
			OP_CPX: begin u.kind = K_CMP; u.src = R_X; end
			OP_CPY: begin u.kind = K_CMP; u.src = R_Y; end
			OP_BIT: u.kind = K_BIT;
			OP_INC: begin u.kind = K_INCDEC; u.src = R_MEM; u.dst = R_MEM; end
			OP_DEC: begin
				u.kind = K_INCDEC; u.src = R_MEM; u.dst = R_MEM; u.alt = 1'b1;
			end
			OP_INY: begin u.kind = K_INCDEC; u.src = R_Y; u.dst = R_Y; end
			OP_DEX: begin
				u.kind = K_INCDEC; u.src = R_X; u.dst = R_X; u.alt = 1'b1;
			end
			OP_DEY: begin
				u.kind = K_INCDEC; u.src = R_Y; u.dst = R_Y; u.alt = 1'b1;
			end
			[OP_ASLM:OP_RORM]: begin
				u.kind = K_SHIFT; u.src = R_MEM; u.dst = R_MEM;
				u.alt = (op == OP_LSRM) || (op == OP_RORM);
				u.rotate = (op == OP_ROLM) || (op == OP_RORM);
			end
			[OP_ASLA:OP_RORA]: begin
				u.kind = K_SHIFT; u.src = R_A; u.dst = R_A;
				u.alt = (op == OP_LSRA) || (op == OP_RORA);
				u.rotate = (op == OP_ROLA) || (op == OP_RORA);
			end
			OP_TAX: begin u.kind = K_TRANSFER; u.src = R_A; u.dst = R_X; end
			OP_TAY: begin u.kind = K_TRANSFER; u.src = R_A; u.dst = R_Y; end
			OP_TXA: begin u.kind = K_TRANSFER; u.src = R_X; u.dst = R_A; end
			OP_TYA: begin u.kind = K_TRANSFER; u.src = R_Y; u.dst = R_A; end
			OP_SEC: begin u.kind = K_FLAGC; u.bval = 1'b1; end
			OP_CLC: u.kind = K_FLAGC;
			OP_JMP: u.kind = K_JUMP;
			[OP_BPL:OP_BVS]: begin
				// Pairs of opcodes test one flag, clear first then set.
				u.kind = K_BRANCH;
				u.bflag = bflag_t'(boff[2:1]);
				u.bval = boff[0];
			end
			default: u.kind = K_NOP;
		endcase
		return u;
	endfunction

	assign in_stall = q_stat.full;
	assign push = in_valid && !q_stat.full;

	always_comb begin
		push_data.uop = decode(opcode);
		push_data.address = address;
		push_data.mem_data = mem_data;
	end

endmodule

// ----- hdl/ce8_queue.sv -----
// Short queue of decoded words between front and back end.
module ce8_queue import ce8_pkg::*; #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t pop_data,
	output qstat_t q_stat
);

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

	entry_t          store_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign q_stat.full = (count_q == FullCnt);
	assign q_stat.empty = (count_q == '0);
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/ce8_back.sv -----
// Back end: register file, flag logic and the result register.
module ce8_back import ce8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qstat_t      q_stat,
	input  entry_t      pop_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        mem_write,
	output logic [7:0]  write_data,
	output logic        pc_load,
	output logic [15:0] pc_value,
	output logic [7:0]  acc_out,
	output logic [7:0]  xreg_out,
	output logic [7:0]  yreg_out,
	output logic [7:0]  flags_out
);

	logic [7:0]  a_q, x_q, y_q, p_q;
	logic        out_valid_q, wr_q, jump_q;
	logic [7:0]  wd_q;
	logic [15:0] pcv_q;

	uop_t        u;
	logic [7:0]  m, opnd, b, res, a_n, x_n, y_n, p_n, wd_n;
	logic [8:0]  sum, diff;
	logic        cin, wr_n, jump_n, flag_sel, set_zn;

	assign u = pop_data.uop;
	assign m = pop_data.mem_data;

	// Take the next word when the result register is empty or being drained.
	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	always_comb begin
		case (u.src)
			R_A:     opnd = a_q;
			R_X:     opnd = x_q;
			R_Y:     opnd = y_q;
			R_MEM:   opnd = m;
			default: opnd = m;
		endcase

		b = u.alt ? ~m : m;
		sum = {1'b0, a_q} + {1'b0, b} + {8'd0, p_q[FlagC]};
		diff = {1'b0, opnd} - {1'b0, m};
		cin = u.rotate & p_q[FlagC];

		case (u.bflag)
			BF_N:    flag_sel = p_q[FlagN];
			BF_C:    flag_sel = p_q[FlagC];
			BF_Z:    flag_sel = p_q[FlagZ];
			BF_V:    flag_sel = p_q[FlagV];
			default: flag_sel = p_q[FlagN];
		endcase

		a_n = a_q;
		x_n = x_q;
		y_n = y_q;
		p_n = p_q;
		wr_n = 1'b0;
		wd_n = 8'd0;
		jump_n = 1'b0;
		res = opnd;
		set_zn = 1'b0;

		case (u.kind)
			K_LOAD: begin res = m; set_zn = 1'b1; end
			K_STORE: begin wr_n = 1'b1; wd_n = opnd; end
			K_ADD: begin
				res = sum[7:0];
				set_zn = 1'b1;
				p_n[FlagC] = sum[8];
				p_n[FlagV] = (~(a_q[7] ^ b[7])) & (a_q[7] ^ sum[7]);
			end
			K_LOGIC: begin
				case (u.lop)
					L_AND:   res = a_q & m;
					L_OR:    res = a_q | m;
					L_EOR:   res = a_q ^ m;
					default: res = a_q & m;
				endcase
				set_zn = 1'b1;
			end
			K_CMP: begin
				res = diff[7:0];
				set_zn = 1'b1;
				p_n[FlagC] = ~diff[8];
			end
			K_BIT: begin
				p_n[FlagZ] = ((a_q & m) == 8'd0);
				p_n[FlagN] = m[7];
				p_n[FlagV] = m[6];
			end
			K_INCDEC: begin
				res = u.alt ? opnd - 8'd1 : opnd + 8'd1;
				set_zn = 1'b1;
			end
			K_SHIFT: begin
				if (u.alt) begin
					p_n[FlagC] = opnd[0];
					res = {cin, opnd[7:1]};
				end else begin
					p_n[FlagC] = opnd[7];
					res = {opnd[6:0], cin};
				end
				set_zn = 1'b1;
			end
			K_TRANSFER: set_zn = 1'b1;
			K_FLAGC: p_n[FlagC] = u.bval;
			K_JUMP: jump_n = 1'b1;
			K_BRANCH: jump_n = (flag_sel == u.bval);
			default: ;
		endcase

		if (set_zn) begin
			p_n[FlagZ] = (res == 8'd0);
			p_n[FlagN] = res[7];
		end

		case (u.dst)
			R_A:     a_n = res;
			R_X:     x_n = res;
			R_Y:     y_n = res;
			R_MEM: begin wr_n = 1'b1; wd_n = res; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0;
			x_q <= 8'd0;
			y_q <= 8'd0;
			p_q <= FlagsReset;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				a_q <= a_n;
				x_q <= x_n;
				y_q <= y_n;
				p_q <= p_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wr_q <= wr_n;
			wd_q <= wd_n;
			jump_q <= jump_n;
			pcv_q <= jump_n ? pop_data.address : 16'd0;
		end
	end

	// Register state changes only on pop, so it doubles as the result register.
	assign out_valid = out_valid_q;
	assign mem_write = wr_q;
	assign write_data = wd_q;
	assign pc_load = jump_q;
	assign pc_value = pcv_q;
	assign acc_out = a_q;
	assign xreg_out = x_q;
	assign yreg_out = y_q;
	assign flags_out = p_q;

endmodule

// ----- hdl/cpu8_instruction_execute.sv -----
// Top level of the 8-bit CPU execute unit: front end, word queue, back end.
//
//   channel | handshake           | payload
//   input   | in_valid / in_stall | opcode, address, mem_data
//   output  | out_valid/out_stall | mem_write, write_data, pc_load, pc_value,
//           |                     | acc_out, xreg_out, yreg_out, flags_out
//
// One word per cycle sustained while out_stall stays low; each word passes through
// the queue register and then the result register on its way to result valid.
// Each word is executed by the back end's 8-bit ALU.
// Reset (arst_n low) clears A, X, Y to zero, status to 0x20, empties the queue.
// in_stall rises only when the queue is full; out_stall holds the result
// and, once the queue fills, backs up to the input.
module cpu8_instruction_execute import ce8_pkg::*; #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  mem_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        mem_write,
	output logic [7:0]  write_data,
	output logic        pc_load,
	output logic [15:0] pc_value,
	output logic [7:0]  acc_out,
	output logic [7:0]  xreg_out,
	output logic [7:0]  yreg_out,
	output logic [7:0]  flags_out
);

	qstat_t q_stat;
	logic   push, pop;
	entry_t push_data, pop_data;

	ce8_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.address   (address),
		.mem_data  (mem_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	ce8_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	ce8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.pop_data   (pop_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mem_write  (mem_write),
		.write_data (write_data),
		.pc_load    (pc_load),
		.pc_value   (pc_value),
		.acc_out    (acc_out),
		.xreg_out   (xreg_out),
		.yreg_out   (yreg_out),
		.flags_out  (flags_out)
	);

`ifndef SYNTH
	a_no_write_and_jump: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(mem_write && pc_load))
		else $error("result both writes memory and loads PC");

	a_fixed_status_bits: assert property (@(posedge clk) disable iff (!arst_n)
		flags_out[5:2] == 4'b1000)
		else $error("status bits 2..5 changed");

	a_no_data_without_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mem_write) |-> (write_data == 8'd0))
		else $error("write data nonzero with no write");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty) && !(pop && q_stat.empty))
		else $error("queue status inconsistent");
`endif

endmodule
